FILE: hdl/rpza_pkg.sv
// ---------------------------------------------------------------------------
// rpza_pkg
// Shared types and constants of the RPZA block video decoder.
// ---------------------------------------------------------------------------
package rpza_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CUR_BITS      = 14;
  localparam int DIM_BITS      = 13;
  localparam int BLOCKS_BITS   = 2 * DIM_BITS;
  localparam int CHAN_BITS     = 5;
  localparam int COLOR_BITS    = 16;
  localparam int ROW_BITS      = 64;
  localparam int STATUS_BITS   = 2;
  localparam int OUT_USED      = 4 * ROW_BITS + 2 * COORD_BITS + STATUS_BITS;
  localparam int OUT_BITS      = ((OUT_USED + 7) / 8) * 8;
  localparam int RAW_BYTES     = 30;
  localparam int HDR_BYTES     = 4;
  localparam int IDX_BYTES     = 4;

  localparam logic [4:0] MIX_W_LO = 5'd11;
  localparam logic [4:0] MIX_W_HI = 5'd21;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_BAD_OP  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_PAST    = 2'd2;

  localparam logic [2:0] OP_SKIP  = 3'b100;
  localparam logic [2:0] OP_FILL  = 3'b101;
  localparam logic [2:0] OP_BLEND = 3'b110;
  localparam logic [2:0] OP_BAD   = 3'b111;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [3:0] {
    PH_HDR, PH_OPC, PH_A_LO, PH_DECIDE, PH_RAW, PH_FILL_HI, PH_FILL_LO,
    PH_CA_HI, PH_CA_LO, PH_CB_HI, PH_CB_LO, PH_IDX
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE, S_EMIT, S_SKIP, S_MIX
  } state_t;

  typedef enum logic [1:0] {
    SRC_RAW, SRC_FILL, SRC_BLEND, SRC_ERR
  } src_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] lo;   // 11/32 a + 21/32 b
    logic [CHAN_BITS-1:0] hi;   // 21/32 a + 11/32 b
  } mix_res_t;

endpackage

FILE: hdl/rpza_mix.sv
// ---------------------------------------------------------------------------
// rpza_mix
// Blend unit for one 5-bit color channel, shared over the three channels.
// ---------------------------------------------------------------------------
module rpza_mix import rpza_pkg::*; (
  input  logic [CHAN_BITS-1:0] chan_a,
  input  logic [CHAN_BITS-1:0] chan_b,
  output mix_res_t             res
);

  logic [CHAN_BITS+5:0] sum_lo;
  logic [CHAN_BITS+5:0] sum_hi;

  // weight both ends and drop the 1/32 fraction
  assign sum_lo = MIX_W_LO * chan_a + MIX_W_HI * chan_b;
  assign sum_hi = MIX_W_HI * chan_a + MIX_W_LO * chan_b;
  assign res.lo = sum_lo[CHAN_BITS+4:5];
  assign res.hi = sum_hi[CHAN_BITS+4:5];

endmodule

FILE: hdl/rpza_block_video_decoder.sv
// Output path: raw and fill blocks go from their last byte through S_EMIT to
// the output register; blend blocks first pass S_MIX and the shared blend unit.
// Throughput: header, color and index bytes are taken every cycle while idle;
// the last byte of a raw, fill or blend block, a skip or an unknown opcode
// holds the input until its blocks are done, and output stalls hold it longer.
// Synchronous reset (rst) clears control state and color_a/b, not other stores.
// ---------------------------------------------------------------------------
// rpza_block_video_decoder
// Byte-serial RPZA decoder: parses commands, emits 4x4 blocks with position.
// ---------------------------------------------------------------------------
module rpza_block_video_decoder import rpza_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [DIM_BITS-1:0] cfg_data,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // data_byte
  input  logic                s_axis_tlast,   // frame_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_row0, pixel_row1, pixel_row2, pixel_row3, block_col, block_row, status
  output logic [OUT_BITS-1:0] m_axis_tdata,
  output logic                m_axis_tlast    // last
);

  state_t state, state_next;
  phase_t phase;
  src_t   src;

  logic [DIM_BITS-1:0]    block_columns, block_rows;
  logic [4:0]             bytes_pending;
  logic [5:0]             run_remaining;
  logic [5:0]             cnt;
  logic [1:0]             ch;
  logic [COLOR_BITS-1:0]  color_a, color_b;
  logic [COLOR_BITS-1:0]  raw_colors [16];
  logic [7:0]             index_bytes [IDX_BYTES];
  logic [14:0]            pal1, pal2;
  logic [CUR_BITS-1:0]    cursor_col, cursor_row;
  logic [BLOCKS_BITS-1:0] blocks_left;
  logic                   halted;
  logic                   o_valid, o_last;
  logic [OUT_BITS-1:0]    o_data;

  logic                   in_acc, can_load, active;
  logic                   go_emit, go_skip, go_mix;
  src_t                   go_src;
  logic [5:0]             go_cnt;
  logic                   do_adv, do_load, do_halt;
  logic [STATUS_BITS-1:0] ld_status;
  logic                   ld_last;
  logic [CUR_BITS-1:0]    col_inc, col_next, row_next;
  logic [7:0]             b;
  logic [4:0]             chan_a, chan_b;
  mix_res_t               mix;
  logic [COLOR_BITS-1:0]  pal [4];
  logic [COLOR_BITS-1:0]  pix [16];
  logic [ROW_BITS-1:0]    rows [4];

  assign b             = s_axis_tdata;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign can_load      = !o_valid || m_axis_tready;
  assign active        = (phase != PH_HDR) && !halted;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;
  assign m_axis_tlast  = o_last;

  // decode which job the accepted byte launches
  always_comb begin
    go_emit = 1'b0;
    go_skip = 1'b0;
    go_mix  = 1'b0;
    go_src  = SRC_RAW;
    go_cnt  = 6'd1;
    if (in_acc && active) begin
      unique case (phase)
        PH_RAW: begin
          go_emit = (bytes_pending == 5'(RAW_BYTES - 1));
        end
        PH_FILL_LO: begin
          go_emit = (run_remaining != 6'd0);
          go_src  = SRC_FILL;
          go_cnt  = run_remaining;
        end
        PH_IDX: begin
          go_mix = (bytes_pending == 5'(IDX_BYTES - 1));
        end
        PH_OPC: begin
          if (b[7:5] == OP_SKIP) begin
            go_skip = 1'b1;
            go_cnt  = {1'b0, b[4:0]} + 6'd1;
          end else if (b[7:5] == OP_BAD) begin
            go_emit = 1'b1;
            go_src  = SRC_ERR;
          end
        end
        default: begin
          go_emit = 1'b0;
        end
      endcase
    end
  end

  // cursor advance
  always_comb begin
    col_inc  = cursor_col + CUR_BITS'(1);
    col_next = col_inc;
    row_next = cursor_row;
    if (col_inc >= CUR_BITS'(block_columns)) begin
      col_next = '0;
      row_next = cursor_row + CUR_BITS'(1);
    end
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    do_adv     = 1'b0;
    do_load    = 1'b0;
    do_halt    = 1'b0;
    ld_status  = ST_OK;
    ld_last    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (go_emit) begin
          state_next = S_EMIT;
        end else if (go_skip) begin
          state_next = S_SKIP;
        end else if (go_mix) begin
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        if (ch == 2'd2) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          do_load = 1'b1;
          if (src == SRC_ERR || blocks_left == '0) begin
            ld_status  = (src == SRC_ERR) ? ST_BAD_OP : ST_PAST;
            ld_last    = 1'b1;
            do_halt    = 1'b1;
            state_next = S_IDLE;
          end else begin
            do_adv  = 1'b1;
            ld_last = (cnt == 6'd1);
            if (cnt == 6'd1) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_SKIP: begin
        if (blocks_left == '0) begin
          if (can_load) begin
            do_load    = 1'b1;
            ld_status  = ST_PAST;
            ld_last    = 1'b1;
            do_halt    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          do_adv = 1'b1;
          if (cnt == 6'd1) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // select the channel that the blend unit works on
  always_comb begin
    unique case (ch)
      2'd0: begin
        chan_a = color_a[14:10];
        chan_b = color_b[14:10];
      end
      2'd1: begin
        chan_a = color_a[9:5];
        chan_b = color_b[9:5];
      end
      default: begin
        chan_a = color_a[4:0];
        chan_b = color_b[4:0];
      end
    endcase
  end

  rpza_mix u_mix (
    .chan_a (chan_a),
    .chan_b (chan_b),
    .res    (mix)
  );

  // assemble the block pixels
  always_comb begin
    pal[0] = {1'b0, color_b[14:0]};
    pal[1] = {1'b0, pal1};
    pal[2] = {1'b0, pal2};
    pal[3] = {1'b0, color_a[14:0]};
    for (int i = 0; i < 16; i++) begin
      unique case (src)
        SRC_RAW:   pix[i] = raw_colors[i];
        SRC_FILL:  pix[i] = color_a;
        SRC_BLEND: pix[i] = pal[index_bytes[i / 4][7 - 2 * (i % 4) -: 2]];
        default:   pix[i] = '0;
      endcase
    end
    for (int r = 0; r < 4; r++) begin
      rows[r] = {pix[4 * r + 3], pix[4 * r + 2], pix[4 * r + 1], pix[4 * r]};
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // parser, cursor and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_columns <= DIM_BITS'(1);
      block_rows    <= DIM_BITS'(1);
      phase         <= PH_HDR;
      bytes_pending <= '0;
      run_remaining <= '0;
      cursor_col    <= '0;
      cursor_row    <= '0;
      blocks_left   <= '0;
      halted        <= 1'b0;
      o_valid       <= 1'b0;
      cnt           <= '0;
      ch            <= '0;
      src           <= SRC_RAW;
      color_a       <= '0;
      color_b       <= '0;
    end else begin
      // take configuration writes
      if (cfg_we) begin
        if (cfg_addr == REG_COLS) begin
          block_columns <= cfg_data;
        end else begin
          block_rows <= cfg_data;
        end
      end

      // launch a job
      if (go_emit || go_skip) begin
        src <= go_src;
        cnt <= go_cnt;
      end
      if (go_mix) begin
        ch <= 2'd0;
      end

      // parse the accepted byte
      if (in_acc) begin
        if (phase == PH_HDR) begin
          if (bytes_pending == '0) begin
            blocks_left <= block_columns * block_rows;
            cursor_col  <= '0;
            cursor_row  <= '0;
            halted      <= 1'b0;
          end
          if (bytes_pending == 5'(HDR_BYTES - 1)) begin
            bytes_pending <= '0;
            phase         <= PH_OPC;
          end else begin
            bytes_pending <= bytes_pending + 5'd1;
          end
        end else if (!halted) begin
          unique case (phase)
            PH_A_LO: begin
              color_a[7:0] <= b;
              phase        <= PH_DECIDE;
            end
            PH_DECIDE: begin
              if (b[7]) begin
                run_remaining <= 6'd1;
                color_b       <= {b, 8'h00};
                phase         <= PH_CB_LO;
              end else begin
                raw_colors[0] <= color_a;
                raw_colors[1] <= {b, 8'h00};
                bytes_pending <= 5'd1;
                phase         <= PH_RAW;
              end
            end
            PH_RAW: begin
              if (!bytes_pending[0]) begin
                raw_colors[4'd1 + 4'(bytes_pending[4:1])] <= {b, 8'h00};
              end else begin
                raw_colors[4'd1 + 4'(bytes_pending[4:1])][7:0] <= b;
              end
              if (bytes_pending == 5'(RAW_BYTES - 1)) begin
                bytes_pending <= '0;
                phase         <= PH_OPC;
              end else begin
                bytes_pending <= bytes_pending + 5'd1;
              end
            end
            PH_FILL_HI: begin
              color_a <= {b, 8'h00};
              phase   <= PH_FILL_LO;
            end
            PH_FILL_LO: begin
              color_a[7:0]  <= b;
              run_remaining <= '0;
              phase         <= PH_OPC;
            end
            PH_CA_HI: begin
              color_a <= {b, 8'h00};
              phase   <= PH_CA_LO;
            end
            PH_CA_LO: begin
              color_a[7:0] <= b;
              phase        <= PH_CB_HI;
            end
            PH_CB_HI: begin
              color_b <= {b, 8'h00};
              phase   <= PH_CB_LO;
            end
            PH_CB_LO: begin
              color_b[7:0]  <= b;
              bytes_pending <= '0;
              phase         <= PH_IDX;
            end
            PH_IDX: begin
              index_bytes[bytes_pending[1:0]] <= b;
              if (bytes_pending == 5'(IDX_BYTES - 1)) begin
                bytes_pending <= '0;
                if (run_remaining <= 6'd1) begin
                  run_remaining <= '0;
                  phase         <= PH_OPC;
                end else begin
                  run_remaining <= run_remaining - 6'd1;
                end
              end else begin
                bytes_pending <= bytes_pending + 5'd1;
              end
            end
            default: begin
              run_remaining <= {1'b0, b[4:0]} + 6'd1;
              if (!b[7]) begin
                color_a <= {b, 8'h00};
                phase   <= PH_A_LO;
              end else if (b[7:5] == OP_FILL) begin
                phase <= PH_FILL_HI;
              end else if (b[7:5] == OP_BLEND) begin
                phase <= PH_CA_HI;
              end else begin
                run_remaining <= '0;
                phase         <= PH_OPC;
              end
            end
          endcase
        end
        // drop any unfinished command at frame end
        if (s_axis_tlast) begin
          phase         <= PH_HDR;
          bytes_pending <= '0;
          run_remaining <= '0;
        end
      end

      // blend palette, one channel a cycle
      if (state == S_MIX) begin
        unique case (ch)
          2'd0: begin
            pal1[14:10] <= mix.lo;
            pal2[14:10] <= mix.hi;
          end
          2'd1: begin
            pal1[9:5] <= mix.lo;
            pal2[9:5] <= mix.hi;
          end
          default: begin
            pal1[4:0] <= mix.lo;
            pal2[4:0] <= mix.hi;
          end
        endcase
        ch <= ch + 2'd1;
        if (ch == 2'd2) begin
          src <= SRC_BLEND;
          cnt <= 6'd1;
        end
      end

      // advance the cursor
      if (do_adv) begin
        cursor_col  <= col_next;
        cursor_row  <= row_next;
        blocks_left <= blocks_left - BLOCKS_BITS'(1);
        cnt         <= cnt - 6'd1;
      end
      if (do_halt) begin
        halted <= 1'b1;
      end

      // output register
      if (do_load) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (do_load) begin
      o_last <= ld_last;
      if (ld_status == ST_OK) begin
        o_data <= OUT_BITS'({ld_status, cursor_row[COORD_BITS-1:0],
                             cursor_col[COORD_BITS-1:0],
                             rows[3], rows[2], rows[1], rows[0]});
      end else begin
        o_data <= OUT_BITS'({ld_status, cursor_row[COORD_BITS-1:0],
                             cursor_col[COORD_BITS-1:0], (4 * ROW_BITS)'(0)});
      end
    end
  end

endmodule

FILE: hdl/rpza_check.sv
// ---------------------------------------------------------------------------
// rpza_check
// Port-level checks of the RPZA decoder result stream.
// ---------------------------------------------------------------------------
module rpza_check import rpza_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_BITS-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // an error result ends the results of its byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_USED-1 -: STATUS_BITS] != ST_OK |-> m_axis_tlast)
    else $error("error result not marked last");

  // an error result carries no pixels
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_USED-1 -: STATUS_BITS] != ST_OK
      |-> m_axis_tdata[4*ROW_BITS-1:0] == '0)
    else $error("error result with pixel data");

  // no status code beyond the defined ones
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_USED-1 -: STATUS_BITS] != 2'd3)
    else $error("undefined status code");

endmodule

bind rpza_block_video_decoder rpza_check u_check (.*);
